// ===== design/assert_macros.svh =====
// Assertion macros used by the rotator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted.
`define AVR_ASSERT_NOW(label, rst_n, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, gated off while reset is asserted.
`define AVR_ASSERT_NEXT(label, rst_n, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/avr_pkg.sv =====
// Shared constants and types of the axis-angle vector rotator.
package avr_pkg;

  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CORDIC_W     = 33;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_e;

endpackage

// ===== design/avr_fmul.sv =====
// Signed fixed-point multiply, rounded half away from zero after the fraction shift.
module avr_fmul #(
  parameter int unsigned AW = 16,
  parameter int unsigned BW = 16,
  parameter int unsigned RW = 18,
  parameter int unsigned F  = 14
) (
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [RW-1:0] p_o
);

  localparam int unsigned PW = AW + BW;

  logic signed [PW-1:0] prod;
  logic        [PW-1:0] mag;
  logic        [PW:0]   rnd;
  logic        [RW-1:0] res;

  always_comb begin
    prod = a_i * b_i;
    mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);
    rnd  = ({1'b0, mag} + ((PW+1)'(1) << (F - 1))) >> F;
    res  = RW'(rnd);
    p_o  = prod[PW-1] ? $signed(-res) : $signed(res);
  end

endmodule

// ===== design/avr_cordic.sv =====
// Pipelined rotation-mode CORDIC giving cosine and sine of a binary angle.
module avr_cordic #(
  parameter int unsigned COMP_WIDTH  = 16,
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ANGLE_WIDTH-1:0]       angle_i,
  output logic signed [COMP_WIDTH-1:0] cos_o,
  output logic signed [COMP_WIDTH-1:0] sin_o
);

  localparam int unsigned N  = avr_pkg::CORDIC_STEPS;
  localparam int unsigned XW = avr_pkg::CORDIC_W;
  localparam int unsigned SH = 32 - COMP_WIDTH;

  logic signed [XW-1:0] x_q [N+1];
  logic signed [XW-1:0] y_q [N+1];
  logic signed [XW-1:0] z_q [N+1];
  logic [1:0]           quad_q [N+1];
  logic [31:0]          a32;

  assign a32 = 32'(angle_i) << (32 - ANGLE_WIDTH);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= avr_pkg::CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= XW'({2'b00, a32[29:0]});
      quad_q[0] <= a32[31:30];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [XW-1:0] dx, dy, da;
    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;
    assign da = XW'(avr_pkg::ATAN_TAB[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][XW-1]) begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + dx;
          z_q[i+1] <= z_q[i] - da;
        end else begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - dx;
          z_q[i+1] <= z_q[i] + da;
        end
        quad_q[i+1] <= quad_q[i];
      end
    end
  end

  logic signed [XW-1:0] c_raw, s_raw;
  logic signed [COMP_WIDTH-1:0] c_d, s_d, c_q, s_q;

  always_comb begin
    unique case (avr_pkg::quad_e'(quad_q[N]))
      avr_pkg::QUAD_I:   begin c_raw = x_q[N];  s_raw = y_q[N];  end
      avr_pkg::QUAD_II:  begin c_raw = -y_q[N]; s_raw = x_q[N];  end
      avr_pkg::QUAD_III: begin c_raw = -x_q[N]; s_raw = -y_q[N]; end
      default:           begin c_raw = y_q[N];  s_raw = -x_q[N]; end
    endcase
  end

  if (SH == 0) begin : g_noround
    assign c_d = COMP_WIDTH'(c_raw);
    assign s_d = COMP_WIDTH'(s_raw);
  end else begin : g_round
    logic [XW-1:0] cm, sm, cr, sr;
    always_comb begin
      cm  = c_raw[XW-1] ? XW'(-c_raw) : XW'(c_raw);
      sm  = s_raw[XW-1] ? XW'(-s_raw) : XW'(s_raw);
      cr  = (cm + (XW'(1) << (SH - 1))) >> SH;
      sr  = (sm + (XW'(1) << (SH - 1))) >> SH;
      c_d = c_raw[XW-1] ? -COMP_WIDTH'(cr) : COMP_WIDTH'(cr);
      s_d = s_raw[XW-1] ? -COMP_WIDTH'(sr) : COMP_WIDTH'(sr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
      s_q <= s_d;
    end
  end

  assign cos_o = c_q;
  assign sin_o = s_q;

endmodule

// ===== design/axis_angle_vector_rotator.sv =====
// Top level of the streaming axis-angle vector rotator.
// This block rotates a 3D vector about a rotation axis by a binary angle with the
// Rodrigues formula, rot = v*cos + (k x v)*sin + k*(k.v)*(1-cos), in signed Q1.F
// fixed point with F = COMP_WIDTH-2. The axis is used as given, without
// normalizing. Cosine and sine come from a 30-stage pipelined CORDIC; each
// product is rounded half away from zero and each output component saturates.
// One beat is accepted per clock while the pipeline is not stalled. The pipeline
// has 32 register stages for the CORDIC (its angle register, 30 iterations and
// the rounded output) plus three stages that scale the axis term, add and
// saturate. The whole pipeline advances together: it holds only while a
// finished result waits at the output and the downstream side is not ready,
// so nothing is lost or repeated.
`include "assert_macros.svh"

module axis_angle_vector_rotator #(
  parameter int unsigned COMP_WIDTH  = 16,
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle, zero fill
  input  logic [((6*COMP_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // rot_x, rot_y, rot_z, zero fill
  output logic [((3*COMP_WIDTH+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned W   = COMP_WIDTH;
  localparam int unsigned F   = COMP_WIDTH - 2;
  localparam int unsigned N   = avr_pkg::CORDIC_STEPS;
  localparam int unsigned LAT = N + 5;
  localparam int unsigned PRW = W + 2;  // single rounded product k*v
  localparam int unsigned DPW = W + 4;  // dot product
  localparam int unsigned CRW = W + 3;  // cross product component
  localparam int unsigned DMW = W + 5;  // dot times (1 - cos)
  localparam int unsigned OMW = W + 2;  // 1 - cos
  localparam int unsigned TW  = W + 8;  // final sum
  localparam int unsigned GW  = 6*W + DPW + 3*CRW;
  localparam int unsigned OTW = ((3*COMP_WIDTH+7)/8)*8;

  logic en;
  logic accept;
  logic [LAT-1:0] vld_q, vld_d;

  assign en              = !vld_q[LAT-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;
  assign m_axis_tvalid_o = vld_q[LAT-1];

  assign vld_d = {vld_q[LAT-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // Input fields.
  logic signed [W-1:0] v_in [3];
  logic signed [W-1:0] k_in [3];
  logic [ANGLE_WIDTH-1:0] ang_in;

  for (genvar j = 0; j < 3; j++) begin : g_unpack
    assign v_in[j] = s_axis_tdata_i[j*W +: W];
    assign k_in[j] = s_axis_tdata_i[(3+j)*W +: W];
  end
  assign ang_in = s_axis_tdata_i[6*W +: ANGLE_WIDTH];

  // Sine and cosine.
  logic signed [W-1:0] cs, sn;

  avr_cordic #(
    .COMP_WIDTH (COMP_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(ang_in),
    .cos_o  (cs),
    .sin_o  (sn)
  );

  // Stage one: the nine products of axis and vector components.
  // Index 3*a+b holds k[a]*v[b].
  logic signed [PRW-1:0] kv [9];
  logic signed [PRW-1:0] kv_q [9];
  logic signed [W-1:0]   v1_q [3];
  logic signed [W-1:0]   k1_q [3];

  for (genvar a = 0; a < 3; a++) begin : g_kva
    for (genvar b = 0; b < 3; b++) begin : g_kvb
      avr_fmul #(.AW(W), .BW(W), .RW(PRW), .F(F)) u_kv (
        .a_i(k_in[a]), .b_i(v_in[b]), .p_o(kv[3*a+b])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kv_q <= kv;
      v1_q <= v_in;
      k1_q <= k_in;
    end
  end

  // Stage two: dot product and cross product k x v.
  logic signed [DPW-1:0] dp_d;
  logic signed [CRW-1:0] w_d [3];

  always_comb begin
    dp_d   = DPW'(kv_q[0]) + DPW'(kv_q[4]) + DPW'(kv_q[8]);
    w_d[0] = CRW'(kv_q[5]) - CRW'(kv_q[7]);
    w_d[1] = CRW'(kv_q[6]) - CRW'(kv_q[2]);
    w_d[2] = CRW'(kv_q[1]) - CRW'(kv_q[3]);
  end

  // The geometry terms wait in a delay line until the CORDIC catches up.
  logic [GW-1:0] g_d;
  logic [GW-1:0] g2_q;
  logic [GW-1:0] dl_q [N];

  assign g_d = {w_d[2], w_d[1], w_d[0], dp_d,
                k1_q[2], k1_q[1], k1_q[0], v1_q[2], v1_q[1], v1_q[0]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      g2_q  <= g_d;
      dl_q[0] <= g2_q;
      for (int i = 1; i < N; i++) begin
        dl_q[i] <= dl_q[i-1];
      end
    end
  end

  logic signed [W-1:0]   v_a [3];
  logic signed [W-1:0]   k_a [3];
  logic signed [DPW-1:0] dp_a;
  logic signed [CRW-1:0] w_a [3];

  for (genvar j = 0; j < 3; j++) begin : g_align
    assign v_a[j] = dl_q[N-1][j*W +: W];
    assign k_a[j] = dl_q[N-1][(3+j)*W +: W];
    assign w_a[j] = dl_q[N-1][6*W + DPW + j*CRW +: CRW];
  end
  assign dp_a = dl_q[N-1][6*W +: DPW];

  // Stage three: dot times (1 - cos), v*cos and w*sin.
  logic signed [OMW-1:0] omc;
  logic signed [DMW-1:0] dm;
  logic signed [TW-1:0]  vc [3];
  logic signed [TW-1:0]  ws [3];
  logic signed [DMW-1:0] dm_q;
  logic signed [TW-1:0]  vc_q [3];
  logic signed [TW-1:0]  ws_q [3];
  logic signed [W-1:0]   k3_q [3];

  assign omc = (OMW'(1) <<< F) - OMW'(cs);

  avr_fmul #(.AW(DPW), .BW(OMW), .RW(DMW), .F(F)) u_dm (
    .a_i(dp_a), .b_i(omc), .p_o(dm)
  );

  for (genvar j = 0; j < 3; j++) begin : g_s3
    avr_fmul #(.AW(W), .BW(W), .RW(TW), .F(F)) u_vc (
      .a_i(v_a[j]), .b_i(cs), .p_o(vc[j])
    );
    avr_fmul #(.AW(CRW), .BW(W), .RW(TW), .F(F)) u_ws (
      .a_i(w_a[j]), .b_i(sn), .p_o(ws[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm_q <= dm;
      vc_q <= vc;
      ws_q <= ws;
      k3_q <= k_a;
    end
  end

  // Stage four: k*dm and the partial sum of the other two terms.
  logic signed [TW-1:0] kd [3];
  logic signed [TW-1:0] kd_q [3];
  logic signed [TW-1:0] vw_q [3];

  for (genvar j = 0; j < 3; j++) begin : g_s4
    avr_fmul #(.AW(W), .BW(DMW), .RW(TW), .F(F)) u_kd (
      .a_i(k3_q[j]), .b_i(dm_q), .p_o(kd[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kd_q <= kd;
      for (int j = 0; j < 3; j++) begin
        vw_q[j] <= vc_q[j] + ws_q[j];
      end
    end
  end

  // Stage five: final sum and saturation into the output register.
  localparam logic signed [TW-1:0] SAT_HI = TW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] SAT_LO = -TW'(64'sd1 <<< (W - 1));

  logic signed [TW-1:0] tot [3];
  logic [W-1:0]         rot_d [3];
  logic [W-1:0]         rot_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tot[j] = kd_q[j] + vw_q[j];
      if (tot[j] > SAT_HI) begin
        rot_d[j] = W'(SAT_HI);
      end else if (tot[j] < SAT_LO) begin
        rot_d[j] = W'(SAT_LO);
      end else begin
        rot_d[j] = W'(tot[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_q <= rot_d;
    end
  end

  assign m_axis_tdata_o = OTW'({rot_q[2], rot_q[1], rot_q[0]});

  // A stalled pipeline keeps every valid bit where it is.
  `AVR_ASSERT_NEXT(a_stall_holds, rst_ni, !en, $stable(vld_q))
  // An accepted beat always enters the first stage.
  `AVR_ASSERT_NEXT(a_accept_enters, rst_ni, accept, vld_q[0])
  // Input is refused only while a result waits at the output.
  `AVR_ASSERT_NOW(a_ready_stall, rst_ni, !s_axis_tready_o, m_axis_tvalid_o && !m_axis_tready_i)

endmodule
